FILE: hdl/pf_pkg.sv
// Shared types, constants and helpers for the packet fragmenter.
// Used by every module of the block but pf_checker; depends on nothing else.
`default_nettype none

package pf_pkg;

	// Default width of the fragment index space
	localparam int unsigned FRAG_INDEX_BITS_DEF = 16;

	// Register reset values
	localparam logic [15:0] MAX_PAYLOAD_RST = 16'd1400;
	localparam logic [31:0] MAGIC_WORD_RST  = 32'h4652_4147;

	// Register indexes on the configuration port
	localparam logic [0:0] REG_MAX_PAYLOAD = 1'b0;
	localparam logic [0:0] REG_MAGIC_WORD  = 1'b1;

	// Fragment header geometry
	localparam int unsigned HDR_BYTES    = 16;
	localparam int unsigned HDR_IDX_BITS = $clog2(HDR_BYTES);
	localparam int unsigned HDR_BITS     = 8 * HDR_BYTES;

	// Queue between the front and back parts
	localparam int unsigned QUEUE_DEPTH = 4;

	// Fragment count divider: 33-bit dividend, one quotient bit per cycle
	localparam int unsigned DIV_STEPS    = 33;
	localparam int unsigned DIV_CNT_BITS = $clog2(DIV_STEPS);

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV,
		F_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_HDR,
		B_DATA,
		B_REJ
	} back_state_t;

	// One classified input transaction as handed from front to back
	typedef struct packed {
		logic [7:0]  data_byte;
		logic        start;
		logic        reject;
		logic [15:0] frag_total;
		logic [31:0] packet_number;
		logic [31:0] packet_length;
	} frag_entry_t;

	// Data bytes per fragment; payload limits below header plus one byte clamp up
	function automatic logic [15:0] frag_data_size(input logic [15:0] max_payload);
		logic [15:0] mp;
		mp = (max_payload < 16'(HDR_BYTES + 1)) ? 16'(HDR_BYTES + 1) : max_payload;
		return mp - 16'(HDR_BYTES);
	endfunction

endpackage

`default_nettype wire

FILE: hdl/packet_fragmenter.sv
// Top level of the packet fragmenter: configuration registers and the
// front, queue and back parts. Depends on pf_pkg, pf_front, pf_queue, pf_back.
//
// Bytes of a packet go in one per transaction, the first marked by packet_start
// with the packet number and total size; out come fragments of at most
// max_payload bytes (17 if set lower), each opened by a 16-byte little-endian
// header (magic word, packet number, fragment index, fragment count, total
// size). A packet whose fragment count does not fit the index space gives a
// single rejected result and its remaining bytes are dropped. A data byte in
// the middle of a fragment is popped, then emitted by the back part; the first
// byte of each fragment follows the 16 header bytes, each sent through the
// output register. The first byte of each packet also waits in the front part
// for the bit-serial divider that works out the fragment count (33 steps). A
// four-entry queue lets the front keep accepting while the back emits. The user
// must write configuration only while idle; the block does not enforce it.
`default_nettype none

module packet_fragmenter #(
	parameter int unsigned FRAG_INDEX_BITS = pf_pkg::FRAG_INDEX_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [31:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        packet_start,
	input  wire logic [31:0] packet_number,
	input  wire logic [31:0] packet_length,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       out_byte,
	output logic             fragment_last,
	output logic             run_last,
	output logic             rejected
);
	import pf_pkg::*;

	logic [15:0]  max_payload_q;
	logic [31:0]  magic_word_q;
	logic [15:0]  dsz;
	logic         fq_valid, fq_ready;
	logic         qb_valid, qb_ready;
	frag_entry_t  fq_entry, qb_entry;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= MAX_PAYLOAD_RST;
			magic_word_q  <= MAGIC_WORD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_PAYLOAD: max_payload_q <= cfg_wdata[15:0];
				REG_MAGIC_WORD:  magic_word_q  <= cfg_wdata;
				default:         max_payload_q <= max_payload_q;
			endcase
		end
	end

	assign dsz = frag_data_size(max_payload_q);

	pf_front #(
		.FRAG_INDEX_BITS (FRAG_INDEX_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.dsz           (dsz),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_byte     (data_byte),
		.packet_start  (packet_start),
		.packet_number (packet_number),
		.packet_length (packet_length),
		.q_valid       (fq_valid),
		.q_ready       (fq_ready),
		.q_entry       (fq_entry)
	);

	pf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_entry  (fq_entry),
		.out_valid (qb_valid),
		.out_ready (qb_ready),
		.out_entry (qb_entry)
	);

	pf_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.dsz           (dsz),
		.magic_word    (magic_word_q),
		.q_valid       (qb_valid),
		.q_ready       (qb_ready),
		.q_entry       (qb_entry),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_byte      (out_byte),
		.fragment_last (fragment_last),
		.run_last      (run_last),
		.rejected      (rejected)
	);

endmodule

`default_nettype wire

FILE: hdl/pf_divider.sv
// Restoring divider computing the fragment count, one quotient bit per cycle.
// Depends on pf_pkg for the step count and widths.
`default_nettype none

module pf_divider (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [pf_pkg::DIV_STEPS-1:0]  numer,
	input  wire logic [15:0]                   divisor,
	output logic                               done,
	output logic [pf_pkg::DIV_STEPS-1:0]       quotient
);
	import pf_pkg::*;

	logic                    busy_q;
	logic                    done_q;
	logic [DIV_CNT_BITS-1:0] cnt_q;
	logic [15:0]             rem_q;
	logic [15:0]             div_q;
	logic [DIV_STEPS-1:0]    nq_q;
	logic [16:0]             trial;
	logic                    fit;

	// Trial subtraction of the divisor from the shifted remainder
	assign trial = {rem_q, nq_q[DIV_STEPS-1]};
	assign fit   = trial >= {1'b0, div_q};

	assign done     = done_q;
	assign quotient = nq_q;

	// Step counter and completion flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DIV_CNT_BITS'(DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Remainder and dividend/quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			nq_q  <= numer;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fit ? 16'(trial - {1'b0, div_q}) : trial[15:0];
			nq_q  <= {nq_q[DIV_STEPS-2:0], fit};
		end
	end

endmodule

`default_nettype wire

FILE: hdl/pf_front.sv
// Front part: accepts input transactions and classifies packet starts by
// working out the fragment count. Depends on pf_pkg and pf_divider.
`default_nettype none

module pf_front #(
	parameter int unsigned FRAG_INDEX_BITS = pf_pkg::FRAG_INDEX_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [15:0]         dsz,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [7:0]          data_byte,
	input  wire logic                packet_start,
	input  wire logic [31:0]         packet_number,
	input  wire logic [31:0]         packet_length,
	output logic                     q_valid,
	input  wire logic                q_ready,
	output pf_pkg::frag_entry_t      q_entry
);
	import pf_pkg::*;

	// Largest fragment count the index space can carry
	localparam logic [DIV_STEPS-1:0] FRAG_LIMIT =
		(DIV_STEPS'(1) << FRAG_INDEX_BITS) - DIV_STEPS'(1);

	front_state_t          state_q, state_d;
	logic [7:0]            byte_q;
	logic [31:0]           pn_q;
	logic [31:0]           total_q;
	logic                  div_start;
	logic                  div_done;
	logic [DIV_STEPS-1:0]  numer;
	logic [DIV_STEPS-1:0]  quot;

	// Rounded-up division: (total + size - 1) / size
	assign numer = {1'b0, packet_length} + DIV_STEPS'(dsz) - DIV_STEPS'(1);

	pf_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.numer    (numer),
		.divisor  (dsz),
		.done     (div_done),
		.quotient (quot)
	);

	// Next state, handshakes and queue entry
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		q_valid   = 1'b0;
		div_start = 1'b0;
		q_entry   = '{data_byte: data_byte, start: 1'b0, reject: 1'b0,
			frag_total: 16'd0, packet_number: packet_number, packet_length: packet_length};
		case (state_q)
			F_IDLE: begin
				in_ready = q_ready;
				q_valid  = in_valid && !packet_start;
				if (in_valid && q_ready && packet_start) begin
					div_start = 1'b1;
					state_d   = F_DIV;
				end
			end
			F_DIV: begin
				if (div_done) begin
					state_d = F_PUSH;
				end
			end
			F_PUSH: begin
				q_valid = 1'b1;
				q_entry = '{data_byte: byte_q, start: 1'b1, reject: quot > FRAG_LIMIT,
					frag_total: quot[15:0], packet_number: pn_q, packet_length: total_q};
				if (q_ready) begin
					state_d = F_IDLE;
				end
			end
			default: begin
				state_d = F_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Hold the start transaction while the count is worked out
	always_ff @(posedge clk) begin
		if (div_start) begin
			byte_q  <= data_byte;
			pn_q    <= packet_number;
			total_q <= packet_length;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/pf_queue.sv
// Short queue of classified transactions between front and back parts.
// Depends on pf_pkg for the entry type and depth.
`default_nettype none

module pf_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire pf_pkg::frag_entry_t  in_entry,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output pf_pkg::frag_entry_t       out_entry
);
	import pf_pkg::*;

	localparam int unsigned PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	frag_entry_t         mem_q [QUEUE_DEPTH];
	logic [PTR_BITS-1:0] wr_q, rd_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                push, pop;

	function automatic logic [PTR_BITS-1:0] ptr_next(input logic [PTR_BITS-1:0] p);
		return (p == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign in_ready  = cnt_q != CNT_BITS'(QUEUE_DEPTH);
	assign out_valid = cnt_q != '0;
	assign out_entry = mem_q[rd_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= ptr_next(wr_q);
			end
			if (pop) begin
				rd_q <= ptr_next(rd_q);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_entry;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/pf_back.sv
// Back part: keeps the packet and fragment counters and emits header, data
// and rejected results through an output register. Depends on pf_pkg.
`default_nettype none

module pf_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [15:0]          dsz,
	input  wire logic [31:0]          magic_word,
	input  wire logic                 q_valid,
	output logic                      q_ready,
	input  wire pf_pkg::frag_entry_t  q_entry,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [7:0]                out_byte,
	output logic                      fragment_last,
	output logic                      run_last,
	output logic                      rejected
);
	import pf_pkg::*;

	back_state_t             state_q, state_d;
	logic [31:0]             pbo_q;
	logic [15:0]             fbo_q;
	logic [15:0]             fn_q;
	logic [15:0]             ft_q;
	logic [31:0]             pn_q;
	logic [31:0]             total_q;
	logic                    drop_q;
	logic [7:0]              byte_q;
	logic [HDR_IDX_BITS-1:0] hdr_idx_q;

	logic                    out_valid_q;
	logic [7:0]              out_byte_q;
	logic                    frag_last_q;
	logic                    run_last_q;
	logic                    rejected_q;

	logic                    slot_free;
	logic [31:0]             cur_pbo;
	logic [15:0]             cur_fbo;
	logic [31:0]             cur_total;
	logic                    cur_drop;
	logic [HDR_BITS-1:0]     hdr;
	logic [7:0]              hdr_byte;
	logic                    frag_end;
	logic                    pkt_end;
	logic                    out_load;
	logic [7:0]              ld_byte;
	logic                    ld_frag_last;
	logic                    ld_run_last;
	logic                    ld_rejected;

	assign out_valid     = out_valid_q;
	assign out_byte      = out_byte_q;
	assign fragment_last = frag_last_q;
	assign run_last      = run_last_q;
	assign rejected      = rejected_q;
	assign slot_free     = !out_valid_q || out_ready;

	// Counters as a packet start leaves them
	assign cur_pbo   = q_entry.start ? 32'd0 : pbo_q;
	assign cur_fbo   = q_entry.start ? 16'd0 : fbo_q;
	assign cur_total = q_entry.start ? q_entry.packet_length : total_q;
	assign cur_drop  = q_entry.start ? q_entry.reject : drop_q;

	// Little-endian header: magic, packet, fragment index, count, size
	assign hdr      = {total_q, ft_q, fn_q, pn_q, magic_word};
	assign hdr_byte = hdr[{hdr_idx_q, 3'b000} +: 8];

	assign frag_end = ({1'b0, fbo_q} + 17'd1) >= {1'b0, dsz};
	assign pkt_end  = ({1'b0, pbo_q} + 33'd1) >= {1'b0, total_q};

	// Sequence the results of one transaction
	always_comb begin
		state_d      = state_q;
		q_ready      = 1'b0;
		out_load     = 1'b0;
		ld_byte      = hdr_byte;
		ld_frag_last = 1'b0;
		ld_run_last  = 1'b0;
		ld_rejected  = 1'b0;
		case (state_q)
			B_IDLE: begin
				q_ready = 1'b1;
				if (q_valid) begin
					if (q_entry.start && q_entry.reject) begin
						state_d = B_REJ;
					end else if (!cur_drop && (cur_pbo < cur_total)) begin
						state_d = (cur_fbo == 16'd0) ? B_HDR : B_DATA;
					end
				end
			end
			B_HDR: begin
				if (slot_free) begin
					out_load = 1'b1;
					if (hdr_idx_q == HDR_IDX_BITS'(HDR_BYTES - 1)) begin
						state_d = B_DATA;
					end
				end
			end
			B_DATA: begin
				ld_byte      = byte_q;
				ld_frag_last = frag_end || pkt_end;
				ld_run_last  = 1'b1;
				if (slot_free) begin
					out_load = 1'b1;
					state_d  = B_IDLE;
				end
			end
			B_REJ: begin
				ld_byte     = 8'd0;
				ld_run_last = 1'b1;
				ld_rejected = 1'b1;
				if (slot_free) begin
					out_load = 1'b1;
					state_d  = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	// State register and packet counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			pbo_q     <= '0;
			fbo_q     <= '0;
			fn_q      <= '0;
			ft_q      <= '0;
			pn_q      <= '0;
			total_q   <= '0;
			drop_q    <= 1'b0;
			hdr_idx_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				B_IDLE: begin
					hdr_idx_q <= '0;
					if (q_valid && q_entry.start) begin
						pn_q    <= q_entry.packet_number;
						total_q <= q_entry.packet_length;
						pbo_q   <= '0;
						fbo_q   <= '0;
						fn_q    <= '0;
						drop_q  <= q_entry.reject;
						ft_q    <= q_entry.reject ? 16'd0 : q_entry.frag_total;
					end
				end
				B_HDR: begin
					if (slot_free) begin
						hdr_idx_q <= hdr_idx_q + 1'b1;
					end
				end
				B_DATA: begin
					if (slot_free) begin
						pbo_q <= pbo_q + 32'd1;
						if (frag_end) begin
							fbo_q <= '0;
							fn_q  <= fn_q + 16'd1;
						end else begin
							fbo_q <= fbo_q + 16'd1;
						end
					end
				end
				default: begin
					hdr_idx_q <= hdr_idx_q;
				end
			endcase
		end
	end

	// Hold the data byte of the transaction at work
	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && q_valid) begin
			byte_q <= q_entry.data_byte;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_byte_q  <= ld_byte;
			frag_last_q <= ld_frag_last;
			run_last_q  <= ld_run_last;
			rejected_q  <= ld_rejected;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/pf_checker.sv
// Port-level checks on the packet fragmenter's result channel, with the bind
// that attaches them to the top level. Depends on packet_fragmenter.
`default_nettype none

module pf_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] out_byte,
	input wire logic       fragment_last,
	input wire logic       run_last,
	input wire logic       rejected
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
		$stable(fragment_last) && $stable(run_last) && $stable(rejected))
		else $error("result changed while stalled");

	// A rejected result stands alone and carries no byte
	a_reject_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rejected |-> run_last && !fragment_last && out_byte == 8'd0)
		else $error("rejected result malformed");

	// Header bytes never close a fragment nor reject
	a_header_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !run_last |-> !fragment_last && !rejected)
		else $error("header byte carries data flags");

endmodule

bind packet_fragmenter pf_checker u_pf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.out_byte      (out_byte),
	.fragment_last (fragment_last),
	.run_last      (run_last),
	.rejected      (rejected)
);

`default_nettype wire

FILE: tb/sv/tb.sv
// Self-checking testbench for packet_fragmenter: a directed table, then random packet phases.
// Depends on pf_pkg and packet_fragmenter; expected bytes come from an in-bench fragment predictor.

module tb;
	import pf_pkg::*;

	localparam int CLK_HIGH       = 4;
	localparam int CLK_LOW        = 4;
	localparam int RESET_CYCLES   = 6;
	localparam int SETTLE_CYCLES  = 80;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASES         = 8;
	localparam int PHASE_ITEMS    = 26;
	localparam int DIR_ROWS       = 25;
	localparam int MAX_RUN        = 17;

	localparam logic [63:0] FRAG_LIMIT = (64'd1 << FRAG_INDEX_BITS_DEF) - 64'd1;

	typedef enum logic [1:0] {
		IDLE_NONE,
		IDLE_SEND,
		IDLE_RECV,
		IDLE_BOTH
	} idle_mode_t;

	typedef enum logic {
		ROW_ITEM,
		ROW_CFG
	} row_kind_t;

	// How a directed row is checked: by the predictor, by a typed-in outcome or not at all
	typedef enum logic [1:0] {
		CHK_MODEL,
		CHK_NONE,
		CHK_REJECT
	} row_chk_t;

	typedef struct packed {
		logic [7:0] ob;
		logic       frag_end;
		logic       run_end;
		logic       rej;
	} frag_res_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [0:0]  reg_sel;
		logic [31:0] reg_val;
		logic [7:0]  db;
		logic        st;
		logic [31:0] pn;
		logic [31:0] ts;
		row_chk_t    chk;
	} dir_row_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        cfg_we        = 1'b0;
	logic [0:0]  cfg_index     = '0;
	logic [31:0] cfg_wdata     = '0;
	logic        in_valid      = 1'b0;
	logic [7:0]  data_byte     = '0;
	logic        packet_start  = 1'b0;
	logic [31:0] packet_number = '0;
	logic [31:0] packet_length = '0;
	logic        out_ready     = 1'b0;
	logic        in_ready;
	logic        out_valid;
	logic [7:0]  out_byte;
	logic        fragment_last;
	logic        run_last;
	logic        rejected;

	packet_fragmenter dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_byte     (data_byte),
		.packet_start  (packet_start),
		.packet_number (packet_number),
		.packet_length (packet_length),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_byte      (out_byte),
		.fragment_last (fragment_last),
		.run_last      (run_last),
		.rejected      (rejected)
	);

	always begin
		#CLK_HIGH clk = 1'b1;
		#CLK_LOW clk = 1'b0;
	end

	// Shadow registers and fragmenter state of the predictor
	logic [15:0] sh_max_payload = MAX_PAYLOAD_RST;
	logic [31:0] sh_magic       = MAGIC_WORD_RST;
	logic [31:0] pkt_off        = '0;
	logic [15:0] frag_off       = '0;
	logic [15:0] frag_idx       = '0;
	logic [15:0] frag_count     = '0;
	logic [31:0] pkt_num        = '0;
	logic [31:0] pkt_total      = '0;
	logic        pkt_dropping   = 1'b0;

	frag_res_t pred_res [MAX_RUN];
	int        pred_n;
	frag_res_t expected_bytes [$];
	dir_row_t  dir_rows [DIR_ROWS];

	int err_cnt     = 0;
	int n_items     = 0;
	int n_results   = 0;
	int n_frags     = 0;
	int n_rejects   = 0;
	int n_cfg       = 0;
	int send_pct    = 0;
	int recv_pct    = 0;
	int hold_req    = 0;
	int hold_ack    = 0;
	int hold_left   = 0;
	int idle_cycles = 0;

	function automatic logic [15:0] data_per_frag();
		logic [15:0] mp;
		mp = sh_max_payload;
		if (mp < 16'(HDR_BYTES + 1))
			mp = 16'(HDR_BYTES + 1);
		return mp - 16'(HDR_BYTES);
	endfunction

	// Work out the result bytes that one accepted input transaction causes
	task automatic predict_fragments(input logic [7:0] db, input logic st,
			input logic [31:0] pn, input logic [31:0] ts);
		logic [15:0] dsz;
		logic [63:0] count;
		logic [31:0] hdr [4];
		logic [31:0] word;
		logic        fin;
		dsz = data_per_frag();
		pred_n = 0;
		if (st) begin
			count = ({32'd0, ts} + 64'(dsz) - 64'd1) / 64'(dsz);
			pkt_num = pn;
			pkt_total = ts;
			pkt_off = '0;
			frag_off = '0;
			frag_idx = '0;
			if (count > FRAG_LIMIT) begin
				pkt_dropping = 1'b1;
				frag_count = '0;
				pred_res[0] = '{8'h00, 1'b0, 1'b1, 1'b1};
				pred_n = 1;
				return;
			end
			pkt_dropping = 1'b0;
			frag_count = count[15:0];
		end
		// drop bytes of a rejected packet and bytes past its end
		if (pkt_dropping || pkt_off >= pkt_total)
			return;
		if (frag_off == 0) begin
			hdr[0] = sh_magic;
			hdr[1] = pkt_num;
			hdr[2] = {frag_count, frag_idx};
			hdr[3] = pkt_total;
			for (int i = 0; i < 16; i++) begin
				word = hdr[i >> 2] >> (8 * (i & 3));
				pred_res[pred_n] = '{word[7:0], 1'b0, 1'b0, 1'b0};
				pred_n++;
			end
		end
		pkt_off = pkt_off + 32'd1;
		frag_off = frag_off + 16'd1;
		fin = (frag_off >= dsz) || (pkt_off >= pkt_total);
		pred_res[pred_n] = '{db, fin, 1'b0, 1'b0};
		pred_n++;
		if (frag_off >= dsz) begin
			frag_off = '0;
			frag_idx = frag_idx + 16'd1;
		end
		pred_res[pred_n - 1].run_end = 1'b1;
	endtask

	task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] a);
		if (e !== a) begin
			$display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, e, a);
			err_cnt++;
		end
	endtask

	// Compare each output transaction with the oldest expected byte
	always @(posedge clk) begin
		frag_res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_bytes.size() == 0) begin
				$display("%0t: unexpected result: expected none, got byte 0x%0h last %0b/%0b rej %0b",
					$time, out_byte, fragment_last, run_last, rejected);
				err_cnt++;
			end else begin
				want = expected_bytes.pop_front();
				check_field("out_byte", 32'(want.ob), 32'(out_byte));
				check_field("fragment_last", 32'(want.frag_end), 32'(fragment_last));
				check_field("run_last", 32'(want.run_end), 32'(run_last));
				check_field("rejected", 32'(want.rej), 32'(rejected));
				n_results++;
				if (want.frag_end)
					n_frags++;
				if (want.rej)
					n_rejects++;
			end
		end
	end

	// Count cycles without any transaction and give up past the limit
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: watchdog: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// Drive out_ready: honour a requested hold-off, else stall at random
	always @(negedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_left <= HOLD_CYCLES - 1;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_pct);
		end
	end

	task automatic set_idle(input idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				send_pct = 0;
				recv_pct = 0;
			end
			IDLE_SEND: begin
				send_pct = 88;
				recv_pct = 0;
			end
			IDLE_RECV: begin
				send_pct = 0;
				recv_pct = 88;
			end
			default: begin
				send_pct = 11;
				recv_pct = 11;
			end
		endcase
	endtask

	// Offer one input transaction, hold it until accepted, then queue its results
	task automatic drive_item(input logic [7:0] db, input logic st, input logic [31:0] pn,
			input logic [31:0] ts, input row_chk_t chk);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= db;
		packet_start <= st;
		packet_number <= pn;
		packet_length <= ts;
		@(posedge clk);
		while (in_ready !== 1'b1)
			@(posedge clk);
		predict_fragments(db, st, pn, ts);
		n_items++;
		case (chk)
			CHK_MODEL: begin
				for (int i = 0; i < pred_n; i++)
					expected_bytes.insert(expected_bytes.size(), pred_res[i]);
			end
			CHK_REJECT: expected_bytes.insert(expected_bytes.size(),
				frag_res_t'{8'h00, 1'b0, 1'b1, 1'b1});
			default: ;
		endcase
	endtask

	task automatic wait_drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_bytes.size() != 0)
			@(posedge clk);
	endtask

	// Drain, then give the block time to finish bytes that cause no result
	task automatic settle();
		wait_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [0:0] sel, input logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= sel;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (sel == REG_MAX_PAYLOAD)
			sh_max_payload = val[15:0];
		else
			sh_magic = val;
		n_cfg++;
	endtask

	task automatic send_byte(input logic st, input logic [31:0] ts, inout int counted);
		drive_item(8'($urandom), st, $urandom, ts, CHK_MODEL);
		counted++;
	endtask

	// Mostly well-formed packets; the rest overrun, abandon, reject or carry no bytes
	task automatic random_packet(inout int counted);
		int          sel;
		int          cap;
		int          follow;
		logic [31:0] tsz;
		cap = 3 * int'(data_per_frag()) + 2;
		if (cap > 40)
			cap = 40;
		sel = $urandom_range(0, 99);
		if (sel < 70) begin
			tsz = $urandom_range(1, cap);
			follow = int'(tsz) - 1;
		end else if (sel < 78) begin
			tsz = $urandom_range(1, cap);
			follow = int'(tsz) - 1 + $urandom_range(1, 3);
		end else if (sel < 86) begin
			tsz = $urandom_range(4, cap + 4);
			follow = $urandom_range(0, int'(tsz) - 2);
		end else if (sel < 93) begin
			tsz = $urandom | 32'h8000_0000;
			follow = $urandom_range(0, 3);
		end else if (sel < 96) begin
			tsz = '0;
			follow = $urandom_range(0, 2);
		end else begin
			tsz = $urandom;
			follow = $urandom_range(0, 3);
		end
		send_byte(1'b1, tsz, counted);
		for (int k = 0; k < follow && counted < PHASE_ITEMS; k++)
			send_byte(1'b0, $urandom, counted);
	endtask

	function automatic logic [31:0] pick_max_payload();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 55)
			return 32'($urandom_range(17, 40));
		else if (sel < 80)
			return 32'($urandom_range(41, 600));
		else if (sel < 90)
			return 32'd17;
		else if (sel < 95)
			return 32'd65535;
		return 32'($urandom_range(17, 65535));
	endfunction

	function automatic dir_row_t item_row(input logic [7:0] db, input logic st,
			input logic [31:0] pn, input logic [31:0] ts, input row_chk_t chk);
		dir_row_t r;
		r = '0;
		r.kind = ROW_ITEM;
		r.db = db;
		r.st = st;
		r.pn = pn;
		r.ts = ts;
		r.chk = chk;
		return r;
	endfunction

	function automatic dir_row_t cfg_row(input logic [0:0] sel, input logic [31:0] val);
		dir_row_t r;
		r = '0;
		r.kind = ROW_CFG;
		r.reg_sel = sel;
		r.reg_val = val;
		r.chk = CHK_NONE;
		return r;
	endfunction

	initial begin
		int       counted;
		bit       paused;
		dir_row_t row;

		// stray byte, empty packet, rejection, then short packets at reset settings
		dir_rows[0]  = item_row(8'h5A, 1'b0, 32'h0, 32'h0, CHK_NONE);
		dir_rows[1]  = item_row(8'h00, 1'b1, 32'h0, 32'h0, CHK_NONE);
		dir_rows[2]  = item_row(8'h33, 1'b1, 32'h1, 32'hFFFF_FFFF, CHK_REJECT);
		dir_rows[3]  = item_row(8'h44, 1'b0, 32'h0, 32'h0, CHK_NONE);
		dir_rows[4]  = item_row(8'hFF, 1'b1, 32'hFFFF_FFFF, 32'd3, CHK_MODEL);
		dir_rows[5]  = item_row(8'h00, 1'b0, 32'h0, 32'h0, CHK_MODEL);
		dir_rows[6]  = item_row(8'hA5, 1'b0, 32'h0, 32'h0, CHK_MODEL);
		dir_rows[7]  = item_row(8'h11, 1'b0, 32'h0, 32'h0, CHK_NONE);
		dir_rows[8]  = item_row(8'h80, 1'b1, 32'h0, 32'd4, CHK_MODEL);
		dir_rows[9]  = item_row(8'h01, 1'b0, 32'h0, 32'h0, CHK_MODEL);
		// restart in the middle of a packet
		dir_rows[10] = item_row(8'h7F, 1'b1, 32'd7, 32'd1, CHK_MODEL);
		// one data byte per fragment: count at the limit, then one past it
		dir_rows[11] = cfg_row(REG_MAX_PAYLOAD, 32'd17);
		dir_rows[12] = cfg_row(REG_MAGIC_WORD, 32'h0);
		dir_rows[13] = item_row(8'hC3, 1'b1, 32'h1234_5678, 32'd65535, CHK_MODEL);
		dir_rows[14] = item_row(8'h3C, 1'b0, 32'h0, 32'h0, CHK_MODEL);
		dir_rows[15] = item_row(8'h96, 1'b1, 32'd9, 32'd65536, CHK_REJECT);
		// payload limit at the header size clamps up
		dir_rows[16] = cfg_row(REG_MAX_PAYLOAD, 32'd16);
		dir_rows[17] = item_row(8'h5A, 1'b1, 32'hAAAA_AAAA, 32'd2, CHK_MODEL);
		dir_rows[18] = item_row(8'hA5, 1'b0, 32'h0, 32'h0, CHK_MODEL);
		dir_rows[19] = cfg_row(REG_MAX_PAYLOAD, 32'd65535);
		dir_rows[20] = cfg_row(REG_MAGIC_WORD, 32'hFFFF_FFFF);
		dir_rows[21] = item_row(8'hE7, 1'b1, 32'h5555_5555, 32'h0001_0000, CHK_MODEL);
		dir_rows[22] = item_row(8'h18, 1'b0, 32'h0, 32'h0, CHK_MODEL);
		dir_rows[23] = cfg_row(REG_MAX_PAYLOAD, 32'(MAX_PAYLOAD_RST));
		dir_rows[24] = cfg_row(REG_MAGIC_WORD, MAGIC_WORD_RST);

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		set_idle(IDLE_NONE);

		// walk the directed table
		for (int i = 0; i < DIR_ROWS; i++) begin
			row = dir_rows[i];
			if (row.kind == ROW_CFG) begin
				settle();
				write_reg(row.reg_sel, row.reg_val);
			end else begin
				drive_item(row.db, row.st, row.pn, row.ts, row.chk);
			end
		end

		// random phases, each with fresh registers and one of four idling patterns
		paused = 1'b0;
		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			write_reg(REG_MAX_PAYLOAD, pick_max_payload());
			write_reg(REG_MAGIC_WORD, $urandom);
			set_idle(idle_mode_t'(ph % 4));
			if (ph == 0)
				hold_req++;
			counted = 0;
			while (counted < PHASE_ITEMS) begin
				if (ph == 4 && !paused && counted >= PHASE_ITEMS / 2) begin
					wait_drain();
					paused = 1'b1;
				end
				random_packet(counted);
			end
		end
		settle();

		$display("Covered %0d input and %0d output transactions: %0d fragments, %0d rejects",
			n_items, n_results, n_frags, n_rejects);
		$display("across %0d register writes and %0d random phases of mixed idling",
			n_cfg, PHASES);
		if (err_cnt == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
